>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the ordered value list
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define OVL_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define OVL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/ovl_pkg.sv
// Types, codes and controller/datapath interface structs of the ordered value list
package ovl_pkg;

   localparam int LIST_DEPTH_DEF = 16;
   localparam int DATA_W         = 32;

   // Operation codes of a request
   localparam logic [1:0] ACT_INSERT   = 2'd0;
   localparam logic [1:0] ACT_DELETE   = 2'd1;
   localparam logic [1:0] ACT_TRAVERSE = 2'd2;

   // Status codes of a response
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [1:0]               action;
      logic signed [DATA_W-1:0] operand_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] entry_value;
      logic [1:0]               status;
      logic                     last_of_run;
   } rsp_type;

   // Source of the response value
   typedef enum logic [1:0] {
      VSEL_OPERAND,
      VSEL_RDATA,
      VSEL_ZERO
   } vsel_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       start;         // latch the request, clear the index
      logic       idx_inc;
      logic       rd_en;
      logic       rd_next;       // read at index + 1 instead of index
      logic       wr_en;
      logic       wr_at_count;   // write at count (append) instead of index
      logic       wr_from_rd;    // write read data instead of operand
      logic       cnt_inc;
      logic       cnt_dec;
      logic       out_load;
      vsel_type   out_vsel;
      logic [1:0] out_status;
      logic       out_last_trav; // last flag from traverse position
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [1:0] action;
      logic       count_zero;
      logic       full;
      logic       idx_at_end;   // index equals entry count
      logic       next_at_end;  // index + 1 reaches entry count
      logic       match;        // read data equals operand
      logic       out_free;     // response register can take a value
   } sts_type;

endpackage

>>> hw/rtl/ordered_value_list_unit.sv
// Ordered value list: top level joining controller and datapath
// Insert appends the operand at the end; delete searches for the operand, then moves each later
// entry down by one; traverse reads and emits every entry in order (one empty response when empty).
// One transaction at a time; the store's single read port paces search, compaction and traverse.
// Reset (synchronous, active high) empties the list and drops any pending response.
`include "assert_macros.svh"

module ordered_value_list_unit #(
   parameter int LIST_DEPTH = ovl_pkg::LIST_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ovl_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ovl_pkg::rsp_type rsp_item
);
   import ovl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ovl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ovl_dp #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // One transaction in work at a time
   `OVL_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && !req_stall, req_stall, "busy")
   // Response register is loaded only when it can take a value
   `OVL_ASSERT_SAME(a_load_when_free, clock, reset, cmd.out_load, sts.out_free, "load while held")
   // Append never happens on a full list
   `OVL_ASSERT_SAME(a_no_overfill, clock, reset, cmd.cnt_inc, !sts.full && cmd.wr_en, "overfill")
   // Removal only from a non-empty list
   `OVL_ASSERT_SAME(a_no_underflow, clock, reset, cmd.cnt_dec, !sts.count_zero, "underflow")

endmodule

>>> hw/rtl/ovl_ram.sv
// Generic single write port, single read port RAM with registered read
module ovl_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, read port with held output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ovl_dp.sv
// Datapath: entry store, count, index, request latch and response register
module ovl_dp #(
   parameter int LIST_DEPTH = ovl_pkg::LIST_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  ovl_pkg::req_type req_item,
   input  ovl_pkg::cmd_type cmd,
   output ovl_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ovl_pkg::rsp_type rsp_item
);
   import ovl_pkg::*;

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   logic [1:0]        action_ff, action_in;
   logic [DATA_W-1:0] operand_ff, operand_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_item_ff, rsp_item_in;

   logic [CNT_W:0]    idx_plus;
   logic [CNT_W:0]    count_ext;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] rd_data;
   logic              trav_last;

   assign idx_plus  = {1'b0, idx_ff} + {{CNT_W{1'b0}}, 1'b1};
   assign count_ext = {1'b0, count_ff};
   assign trav_last = (idx_plus == count_ext);

   // Select store addresses and write data
   assign rd_addr = cmd.rd_next ? idx_plus[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_addr = cmd.wr_at_count ? count_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_data = cmd.wr_from_rd ? rd_data : operand_ff;

   ovl_ram #(
      .WIDTH (DATA_W),
      .DEPTH (LIST_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Latch request, step index and count
   always_comb begin
      action_in  = cmd.start ? req_item.action : action_ff;
      operand_in = cmd.start ? req_item.operand_value : operand_ff;
      idx_in     = idx_ff;
      if (cmd.start) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_plus[CNT_W-1:0];
      end
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + {{(CNT_W-1){1'b0}}, 1'b1};
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - {{(CNT_W-1){1'b0}}, 1'b1};
      end
   end

   // Load or drain the response register
   always_comb begin
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         unique case (cmd.out_vsel)
            VSEL_OPERAND: rsp_item_in.entry_value = operand_ff;
            VSEL_RDATA:   rsp_item_in.entry_value = rd_data;
            VSEL_ZERO:    rsp_item_in.entry_value = '0;
            default:      rsp_item_in.entry_value = '0;
         endcase
         rsp_item_in.status      = cmd.out_status;
         rsp_item_in.last_of_run = cmd.out_last_trav ? trav_last : 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff   <= action_in;
      operand_ff  <= operand_in;
      rsp_item_ff <= rsp_item_in;
   end

   // Report status to the controller
   assign sts.action      = action_ff;
   assign sts.count_zero  = (count_ff == '0);
   assign sts.full        = (count_ff == CNT_W'(LIST_DEPTH));
   assign sts.idx_at_end  = (idx_ff == count_ff);
   assign sts.next_at_end = (idx_plus >= count_ext);
   assign sts.match       = (rd_data == operand_ff);
   assign sts.out_free    = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

>>> hw/rtl/ovl_ctrl.sv
// Controller: sequences insert, delete search and compaction, and traverse
module ovl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ovl_pkg::sts_type sts,
   output ovl_pkg::cmd_type cmd
);
   import ovl_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_INSERT,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_NOT_FOUND,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DEL_DONE,
      S_TRAV_RD,
      S_TRAV_EMIT,
      S_EMPTY
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.action)
               ACT_INSERT:   state_in = S_INSERT;
               ACT_DELETE:   state_in = S_SRCH_RD;
               ACT_TRAVERSE: state_in = sts.count_zero ? S_EMPTY : S_TRAV_RD;
               default:      state_in = S_IDLE;
            endcase
         end
         S_INSERT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_vsel = VSEL_OPERAND;
               if (sts.full) begin
                  cmd.out_status = ST_FULL;
               end else begin
                  cmd.out_status  = ST_OK;
                  cmd.wr_en       = 1'b1;
                  cmd.wr_at_count = 1'b1;
                  cmd.cnt_inc     = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_SRCH_RD: begin
            if (sts.idx_at_end) begin
               state_in = S_NOT_FOUND;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (sts.match) begin
               state_in = S_SHIFT_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SRCH_RD;
            end
         end
         S_NOT_FOUND: begin
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_vsel   = VSEL_OPERAND;
               cmd.out_status = ST_NOT_FOUND;
               state_in       = S_IDLE;
            end
         end
         S_SHIFT_RD: begin
            if (sts.next_at_end) begin
               state_in = S_DEL_DONE;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_en      = 1'b1;
            cmd.wr_from_rd = 1'b1;
            cmd.idx_inc    = 1'b1;
            state_in       = S_SHIFT_RD;
         end
         S_DEL_DONE: begin
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_vsel   = VSEL_OPERAND;
               cmd.out_status = ST_OK;
               cmd.cnt_dec    = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_TRAV_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_TRAV_EMIT;
         end
         S_TRAV_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load      = 1'b1;
               cmd.out_vsel      = VSEL_RDATA;
               cmd.out_status    = ST_OK;
               cmd.out_last_trav = 1'b1;
               cmd.idx_inc       = 1'b1;
               state_in          = sts.next_at_end ? S_IDLE : S_TRAV_RD;
            end
         end
         S_EMPTY: begin
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_vsel   = VSEL_ZERO;
               cmd.out_status = ST_EMPTY;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
